>>> src/epoch_seconds_to_utc_calendar_unit_assert.svh
// Assertion macros used by the checker file of this block.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef EPOCH_SECONDS_TO_UTC_CALENDAR_UNIT_ASSERT_SVH
`define EPOCH_SECONDS_TO_UTC_CALENDAR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define ESUC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ESUC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/esuc_pkg.sv
`default_nettype none

package esuc_pkg;

  localparam int unsigned LAST_YEAR = 9999;

  localparam int unsigned SECS_W   = 38;
  localparam int unsigned YEAR_W   = 13;
  localparam int unsigned MON_W    = 4;
  localparam int unsigned MDAY_W   = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MIN_W    = 6;
  localparam int unsigned SEC_W    = 6;
  localparam int unsigned WDAY_W   = 3;
  localparam int unsigned YDAY_W   = 9;

  // 86400 = 128 * 675: the low seven bits of the seconds pass straight into
  // the remainder, and the rest is divided by 675 with a scaled reciprocal.
  // Rounding the reciprocal up keeps the quotient exact for every 31-bit
  // dividend. The remainder is formed from the registered quotient, so it
  // settles after the quotient does.
  localparam int unsigned LOW_BITS    = 7;
  localparam int unsigned DIVISOR     = 675;
  localparam int unsigned DVD_W       = SECS_W - LOW_BITS;
  localparam int unsigned REM_W       = 10;
  localparam int unsigned RECIP_W     = 32;
  localparam int unsigned RECIP       = 32'd3257812231;
  localparam int unsigned RECIP_SHIFT = 41;
  localparam int unsigned PROD_W      = DVD_W + RECIP_W;
  localparam int unsigned DIV_STEPS   = 2;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int unsigned TOD_W       = REM_W + LOW_BITS;

  localparam int unsigned DAYS_W = 22;
  localparam int unsigned YR_W   = 14;

  // Year counting runs on 400-year cycles starting at 1601-01-01.
  localparam int unsigned BASE_YEAR          = 1601;
  localparam int unsigned DAYS_BASE_TO_EPOCH = 134774;
  localparam int unsigned DAYS_PER_400Y      = 146097;
  localparam int unsigned DAYS_PER_100Y      = 36524;
  localparam int unsigned DAYS_PER_4Y        = 1461;
  localparam int unsigned DAYS_PER_YEAR      = 365;
  localparam int unsigned YEAR_OFFSET        = 1900;

  // Days from 1970-01-01 to January 1 of the year after LAST_YEAR.
  localparam int unsigned DAYS_LIMIT = 365 * (LAST_YEAR + 1 - 1970)
      + LAST_YEAR / 4 - LAST_YEAR / 100 + LAST_YEAR / 400
      - (1969 / 4 - 1969 / 100 + 1969 / 400);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_RANGE, ST_Y400, ST_Y100, ST_Y4, ST_Y1, ST_MON, ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_DIV, OP_INIT, OP_Y400, OP_Y100, OP_Y4, OP_Y1, OP_MON, OP_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic step_ok;
    logic range_err;
    logic out_free;
  } status_t;

  function automatic logic [MDAY_W-1:0] month_len(input logic [MON_W-1:0] mon,
                                                  input logic leap);
    logic [MDAY_W-1:0] len;
    unique case (mon) inside
      4'd1:                    len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

>>> src/esuc_ctrl.sv
`default_nettype none

module esuc_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire esuc_pkg::status_t status_i,
  output esuc_pkg::cmd_t        cmd_o
);

  esuc_pkg::state_e state_q, state_d;
  logic [esuc_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= esuc_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = '0;
    unique case (state_q)
      esuc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = esuc_pkg::ST_DIV;
      end
      esuc_pkg::ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == esuc_pkg::DIV_CNT_W'(esuc_pkg::DIV_STEPS - 1)) begin
          state_d = esuc_pkg::ST_RANGE;
        end
      end
      esuc_pkg::ST_RANGE: state_d = esuc_pkg::ST_Y400;
      esuc_pkg::ST_Y400: begin
        if (status_i.range_err) state_d = esuc_pkg::ST_DONE;
        else if (!status_i.step_ok) state_d = esuc_pkg::ST_Y100;
      end
      esuc_pkg::ST_Y100: begin
        if (!status_i.step_ok) state_d = esuc_pkg::ST_Y4;
      end
      esuc_pkg::ST_Y4: begin
        if (!status_i.step_ok) state_d = esuc_pkg::ST_Y1;
      end
      esuc_pkg::ST_Y1: begin
        if (!status_i.step_ok) state_d = esuc_pkg::ST_MON;
      end
      esuc_pkg::ST_MON: begin
        if (!status_i.step_ok) state_d = esuc_pkg::ST_DONE;
      end
      esuc_pkg::ST_DONE: begin
        if (status_i.out_free) state_d = esuc_pkg::ST_IDLE;
      end
      default: state_d = esuc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op   = esuc_pkg::OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      esuc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = esuc_pkg::OP_LOAD;
      end
      esuc_pkg::ST_DIV:   cmd_o.op = esuc_pkg::OP_DIV;
      esuc_pkg::ST_RANGE: cmd_o.op = esuc_pkg::OP_INIT;
      esuc_pkg::ST_Y400:  cmd_o.op = esuc_pkg::OP_Y400;
      esuc_pkg::ST_Y100:  cmd_o.op = esuc_pkg::OP_Y100;
      esuc_pkg::ST_Y4:    cmd_o.op = esuc_pkg::OP_Y4;
      esuc_pkg::ST_Y1:    cmd_o.op = esuc_pkg::OP_Y1;
      esuc_pkg::ST_MON:   cmd_o.op = esuc_pkg::OP_MON;
      esuc_pkg::ST_DONE: begin
        if (status_i.out_free) cmd_o.op = esuc_pkg::OP_OUT;
      end
      default: cmd_o.op = esuc_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

>>> src/esuc_dp.sv
`default_nettype none

module esuc_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire esuc_pkg::cmd_t                cmd_i,
  output esuc_pkg::status_t                  status_o,
  input  wire logic [esuc_pkg::SECS_W-1:0]   epoch_seconds_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [esuc_pkg::YEAR_W-1:0]        year_since_1900_o,
  output logic [esuc_pkg::MON_W-1:0]         month_index_o,
  output logic [esuc_pkg::MDAY_W-1:0]        day_of_month_o,
  output logic [esuc_pkg::HOUR_W-1:0]        hour_of_day_o,
  output logic [esuc_pkg::MIN_W-1:0]         minute_of_hour_o,
  output logic [esuc_pkg::SEC_W-1:0]         second_of_minute_o,
  output logic [esuc_pkg::WDAY_W-1:0]        weekday_o,
  output logic [esuc_pkg::YDAY_W-1:0]        day_of_year_o,
  output logic                               range_error_o
);

  localparam int unsigned DW = esuc_pkg::DAYS_W;

  // Divider: the quotient comes from a reciprocal product, and the remainder
  // from the dividend minus the registered quotient times the divisor.
  logic [esuc_pkg::LOW_BITS-1:0] low_q;
  logic [esuc_pkg::DVD_W-1:0]    dvd_q;
  logic [DW-1:0]                 quo_q;
  logic [esuc_pkg::REM_W-1:0]    rem_q;
  logic [esuc_pkg::PROD_W-1:0]   recip_prod;
  logic [esuc_pkg::DVD_W-1:0]    quo_back;
  logic [esuc_pkg::DVD_W-1:0]    rem_full;
  logic [DW-1:0]                 days;

  // Calendar stepping.
  logic                         err_q;
  logic [DW-1:0]                dleft_q, dleft_d, sub_val;
  logic [esuc_pkg::YR_W-1:0]    yr_q, yr_d, yr_inc;
  logic [1:0]                   cent_q, cent_d;
  logic [4:0]                   quad_q, quad_d;
  logic [1:0]                   yr1_q, yr1_d;
  logic [esuc_pkg::MON_W-1:0]   mon_q, mon_d;
  logic [esuc_pkg::YDAY_W-1:0]  doy_q;
  logic                         leap, step_ok, can_step;
  logic [esuc_pkg::MDAY_W-1:0]  mlen;

  // Time of day and weekday chain.
  logic [esuc_pkg::TOD_W-1:0]   tod;
  logic [25:0]                  hour_prod;
  logic [esuc_pkg::HOUR_W-1:0]  hour_q;
  logic [esuc_pkg::TOD_W-1:0]   hour_secs;
  logic [esuc_pkg::TOD_W-1:0]   hour_rem;
  logic [11:0]                  msr_q;
  logic [19:0]                  min_prod;
  logic [esuc_pkg::MIN_W-1:0]   min_q;
  logic [11:0]                  sec_full;
  logic [esuc_pkg::SEC_W-1:0]   sec_q;
  logic [22:0]                  wx;
  logic [45:0]                  w_prod;
  logic [19:0]                  wq_q;
  logic [22:0]                  w_rem;
  logic [esuc_pkg::WDAY_W-1:0]  wday_q;

  logic out_valid_q;

  assign recip_prod = esuc_pkg::PROD_W'(dvd_q) * esuc_pkg::PROD_W'(esuc_pkg::RECIP);
  assign quo_back   = esuc_pkg::DVD_W'(quo_q) * esuc_pkg::DVD_W'(esuc_pkg::DIVISOR);
  assign rem_full   = dvd_q - quo_back;
  assign days       = quo_q;

  // A year is leap when it closes a four-year block, except for a century
  // year that does not close the 400-year cycle.
  assign leap = (yr1_q == 2'd3) && !((quad_q == 5'd24) && (cent_q != 2'd3));
  assign mlen = esuc_pkg::month_len(mon_q, leap);

  always_comb begin
    can_step = 1'b0;
    sub_val  = '0;
    yr_inc   = '0;
    unique case (cmd_i.op)
      esuc_pkg::OP_Y400: begin
        can_step = !err_q;
        sub_val  = DW'(esuc_pkg::DAYS_PER_400Y);
        yr_inc   = esuc_pkg::YR_W'(400);
      end
      esuc_pkg::OP_Y100: begin
        can_step = (cent_q != 2'd3);
        sub_val  = DW'(esuc_pkg::DAYS_PER_100Y);
        yr_inc   = esuc_pkg::YR_W'(100);
      end
      esuc_pkg::OP_Y4: begin
        can_step = (quad_q != 5'd24);
        sub_val  = DW'(esuc_pkg::DAYS_PER_4Y);
        yr_inc   = esuc_pkg::YR_W'(4);
      end
      esuc_pkg::OP_Y1: begin
        can_step = (yr1_q != 2'd3);
        sub_val  = DW'(esuc_pkg::DAYS_PER_YEAR);
        yr_inc   = esuc_pkg::YR_W'(1);
      end
      esuc_pkg::OP_MON: begin
        can_step = (mon_q != esuc_pkg::MON_W'(11));
        sub_val  = DW'(mlen);
      end
      default: begin
        can_step = 1'b0;
      end
    endcase
    step_ok = can_step && (dleft_q >= sub_val);
  end

  always_comb begin
    dleft_d = dleft_q;
    yr_d    = yr_q;
    cent_d  = cent_q;
    quad_d  = quad_q;
    yr1_d   = yr1_q;
    mon_d   = mon_q;
    if (step_ok) begin
      dleft_d = dleft_q - sub_val;
      yr_d    = yr_q + yr_inc;
      unique case (cmd_i.op)
        esuc_pkg::OP_Y100: cent_d = cent_q + 2'd1;
        esuc_pkg::OP_Y4:   quad_d = quad_q + 5'd1;
        esuc_pkg::OP_Y1:   yr1_d  = yr1_q + 2'd1;
        esuc_pkg::OP_MON:  mon_d  = mon_q + 1'b1;
        default:           yr_d   = yr_q + yr_inc;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      esuc_pkg::OP_LOAD: begin
        low_q <= epoch_seconds_i[esuc_pkg::LOW_BITS-1:0];
        dvd_q <= epoch_seconds_i[esuc_pkg::SECS_W-1:esuc_pkg::LOW_BITS];
      end
      esuc_pkg::OP_DIV: begin
        quo_q <= recip_prod[esuc_pkg::RECIP_SHIFT +: DW];
        rem_q <= rem_full[esuc_pkg::REM_W-1:0];
      end
      esuc_pkg::OP_INIT: begin
        err_q   <= (days >= DW'(esuc_pkg::DAYS_LIMIT));
        dleft_q <= days + DW'(esuc_pkg::DAYS_BASE_TO_EPOCH);
        yr_q    <= esuc_pkg::YR_W'(esuc_pkg::BASE_YEAR);
        cent_q  <= '0;
        quad_q  <= '0;
        yr1_q   <= '0;
        mon_q   <= '0;
      end
      esuc_pkg::OP_Y400, esuc_pkg::OP_Y100, esuc_pkg::OP_Y4, esuc_pkg::OP_MON: begin
        dleft_q <= dleft_d;
        yr_q    <= yr_d;
        cent_q  <= cent_d;
        quad_q  <= quad_d;
        mon_q   <= mon_d;
      end
      esuc_pkg::OP_Y1: begin
        dleft_q <= dleft_d;
        yr_q    <= yr_d;
        yr1_q   <= yr1_d;
        // The last cycle of this phase leaves the day of the year in place.
        doy_q   <= dleft_d[esuc_pkg::YDAY_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // Time of day and weekday follow the divider result through a short
  // registered chain; they settle well before the calendar stepping ends.
  assign tod       = {rem_q, low_q};
  assign hour_prod = 26'(tod[esuc_pkg::TOD_W-1:4]) * 26'(4661);
  assign hour_secs = esuc_pkg::TOD_W'(hour_q) * esuc_pkg::TOD_W'(3600);
  assign hour_rem  = tod - hour_secs;
  assign min_prod  = 20'(msr_q[11:2]) * 20'(1093);
  assign sec_full  = msr_q - (12'(min_q) * 12'(60));
  assign wx        = 23'(days) + 23'(4);
  assign w_prod    = 46'(wx) * 46'(4793491);
  assign w_rem     = wx - (23'(wq_q) * 23'(7));

  always_ff @(posedge clk_i) begin
    hour_q <= hour_prod[24:20];
    msr_q  <= hour_rem[11:0];
    min_q  <= min_prod[19:14];
    sec_q  <= sec_full[esuc_pkg::SEC_W-1:0];
    wq_q   <= w_prod[44:25];
    wday_q <= w_rem[esuc_pkg::WDAY_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == esuc_pkg::OP_OUT) begin
      range_error_o <= err_q;
      if (err_q) begin
        year_since_1900_o  <= '0;
        month_index_o      <= '0;
        day_of_month_o     <= '0;
        hour_of_day_o      <= '0;
        minute_of_hour_o   <= '0;
        second_of_minute_o <= '0;
        weekday_o          <= '0;
        day_of_year_o      <= '0;
      end else begin
        year_since_1900_o  <= esuc_pkg::YEAR_W'(yr_q - esuc_pkg::YR_W'(esuc_pkg::YEAR_OFFSET));
        month_index_o      <= mon_q;
        day_of_month_o     <= dleft_q[esuc_pkg::MDAY_W-1:0] + 1'b1;
        hour_of_day_o      <= hour_q;
        minute_of_hour_o   <= min_q;
        second_of_minute_o <= sec_q;
        weekday_o          <= wday_q;
        day_of_year_o      <= doy_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == esuc_pkg::OP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o.step_ok   = step_ok;
  assign status_o.range_err = err_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

>>> src/epoch_seconds_to_utc_calendar_unit.sv
// Converts seconds since 1970-01-01 00:00:00 UTC into the Gregorian UTC date
// and time, one transaction at a time. A conversion divides by the seconds
// in a day with a reciprocal product, sets up the calendar walk, then takes
// the 400-year, 100-year, 4-year, single-year and month steps with a closing
// check for each of those phases, and finally loads the output register, so
// later years and later months take longer. That last load waits while the
// previous result is still held at the output. An instant after the last day
// of year 9999 gives only the range flag, with every other field zero. A new
// input is taken as soon as the previous result has been handed to the output
// register, even if that result has not yet been taken downstream.
`default_nettype none

module epoch_seconds_to_utc_calendar_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [esuc_pkg::SECS_W-1:0] epoch_seconds_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [esuc_pkg::YEAR_W-1:0]      year_since_1900_o,
  output logic [esuc_pkg::MON_W-1:0]       month_index_o,
  output logic [esuc_pkg::MDAY_W-1:0]      day_of_month_o,
  output logic [esuc_pkg::HOUR_W-1:0]      hour_of_day_o,
  output logic [esuc_pkg::MIN_W-1:0]       minute_of_hour_o,
  output logic [esuc_pkg::SEC_W-1:0]       second_of_minute_o,
  output logic [esuc_pkg::WDAY_W-1:0]      weekday_o,
  output logic [esuc_pkg::YDAY_W-1:0]      day_of_year_o,
  output logic                             range_error_o
);

  esuc_pkg::cmd_t    cmd;
  esuc_pkg::status_t status;

  esuc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  esuc_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .epoch_seconds_i    (epoch_seconds_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .year_since_1900_o  (year_since_1900_o),
    .month_index_o      (month_index_o),
    .day_of_month_o     (day_of_month_o),
    .hour_of_day_o      (hour_of_day_o),
    .minute_of_hour_o   (minute_of_hour_o),
    .second_of_minute_o (second_of_minute_o),
    .weekday_o          (weekday_o),
    .day_of_year_o      (day_of_year_o),
    .range_error_o      (range_error_o)
  );

endmodule

`default_nettype wire

>>> src/esuc_checker.sv
`default_nettype none

`include "epoch_seconds_to_utc_calendar_unit_assert.svh"

module esuc_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire logic [esuc_pkg::SECS_W-1:0] epoch_seconds_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [esuc_pkg::YEAR_W-1:0] year_since_1900_o,
  input wire logic [esuc_pkg::MON_W-1:0]  month_index_o,
  input wire logic [esuc_pkg::MDAY_W-1:0] day_of_month_o,
  input wire logic [esuc_pkg::HOUR_W-1:0] hour_of_day_o,
  input wire logic [esuc_pkg::MIN_W-1:0]  minute_of_hour_o,
  input wire logic [esuc_pkg::SEC_W-1:0]  second_of_minute_o,
  input wire logic [esuc_pkg::WDAY_W-1:0] weekday_o,
  input wire logic [esuc_pkg::YDAY_W-1:0] day_of_year_o,
  input wire logic                        range_error_o
);

  `ESUC_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(year_since_1900_o) && $stable(day_of_year_o) && $stable(range_error_o), "result changed while stalled")

  `ESUC_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "input taken while a conversion runs")

  `ESUC_ASSERT_IMP(a_err_zero, out_valid_o && range_error_o, year_since_1900_o == '0 && month_index_o == '0 && day_of_month_o == '0 && hour_of_day_o == '0 && minute_of_hour_o == '0 && second_of_minute_o == '0 && weekday_o == '0 && day_of_year_o == '0, "range error with nonzero fields")

  `ESUC_ASSERT_IMP(a_fields_legal, out_valid_o && !range_error_o, year_since_1900_o >= 13'd70 && month_index_o <= 4'd11 && day_of_month_o != '0 && hour_of_day_o <= 5'd23 && minute_of_hour_o <= 6'd59 && second_of_minute_o <= 6'd59 && weekday_o <= 3'd6 && day_of_year_o <= 9'd365, "result field out of range")

endmodule

bind epoch_seconds_to_utc_calendar_unit esuc_checker u_esuc_checker (.*);

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam longint unsigned SECONDS_PER_DAY = 64'd86400;
  localparam longint unsigned LAST_SECOND     = 64'd253402300799;
  localparam longint unsigned TOP_SECOND      = (64'd1 << esuc_pkg::SECS_W) - 64'd1;
  localparam int unsigned     RANDOM_ITEMS    = 1330;
  localparam int unsigned     CALM_ITEMS      = 150;
  localparam int unsigned     STALL_LIMIT     = 2000;
  localparam int unsigned     DRAIN_CYCLES    = 200;

  typedef struct packed {
    logic [esuc_pkg::YEAR_W-1:0] year;
    logic [esuc_pkg::MON_W-1:0]  month;
    logic [esuc_pkg::MDAY_W-1:0] mday;
    logic [esuc_pkg::HOUR_W-1:0] hour;
    logic [esuc_pkg::MIN_W-1:0]  minute;
    logic [esuc_pkg::SEC_W-1:0]  second;
    logic [esuc_pkg::WDAY_W-1:0] wday;
    logic [esuc_pkg::YDAY_W-1:0] yday;
    logic                        range_error;
  } calendar_t;

  typedef struct {
    longint unsigned seconds;
    bit              literal;
    calendar_t       expected;
  } stimulus_row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [esuc_pkg::SECS_W-1:0]   epoch_seconds_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [esuc_pkg::YEAR_W-1:0]   year_since_1900_o;
  logic [esuc_pkg::MON_W-1:0]    month_index_o;
  logic [esuc_pkg::MDAY_W-1:0]   day_of_month_o;
  logic [esuc_pkg::HOUR_W-1:0]   hour_of_day_o;
  logic [esuc_pkg::MIN_W-1:0]    minute_of_hour_o;
  logic [esuc_pkg::SEC_W-1:0]    second_of_minute_o;
  logic [esuc_pkg::WDAY_W-1:0]   weekday_o;
  logic [esuc_pkg::YDAY_W-1:0]   day_of_year_o;
  logic                          range_error_o;

  calendar_t     pending_dates[$];
  stimulus_row_t directed_rows[$];
  int unsigned   error_count;
  int unsigned   stall_cycles;
  bit            idling_on;

  epoch_seconds_to_utc_calendar_unit u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .epoch_seconds_i    (epoch_seconds_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .year_since_1900_o  (year_since_1900_o),
    .month_index_o      (month_index_o),
    .day_of_month_o     (day_of_month_o),
    .hour_of_day_o      (hour_of_day_o),
    .minute_of_hour_o   (minute_of_hour_o),
    .second_of_minute_o (second_of_minute_o),
    .weekday_o          (weekday_o),
    .day_of_year_o      (day_of_year_o),
    .range_error_o      (range_error_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic bit is_leap_year(input longint unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint unsigned days_in_month(input longint unsigned m,
                                                    input longint unsigned y);
    longint unsigned len;
    case (m)
      1:           len = is_leap_year(y) ? 29 : 28;
      3, 5, 8, 10: len = 30;
      default:     len = 31;
    endcase
    return len;
  endfunction

  // Seconds at midnight of the given date; month counts from 0, day from 1.
  function automatic longint unsigned epoch_of(input longint unsigned y,
                                               input longint unsigned m,
                                               input longint unsigned d);
    longint unsigned days;
    longint unsigned k;
    days = 365 * (y - 1970) + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400 - 477;
    for (k = 0; k < m; k++) days += days_in_month(k, y);
    days += d - 1;
    return days * SECONDS_PER_DAY;
  endfunction

  function automatic calendar_t predict_calendar(input longint unsigned secs);
    calendar_t       c;
    longint unsigned days;
    longint unsigned tod;
    longint unsigned yr;
    longint unsigned mon;
    c    = '0;
    secs = secs & TOP_SECOND;
    days = secs / SECONDS_PER_DAY;
    tod  = secs % SECONDS_PER_DAY;
    yr   = 1970;
    while (days >= (is_leap_year(yr) ? 366 : 365)) begin
      days -= is_leap_year(yr) ? 366 : 365;
      yr++;
      if (yr > esuc_pkg::LAST_YEAR) begin
        c.range_error = 1'b1;
        return c;
      end
    end
    c.year = esuc_pkg::YEAR_W'(yr - 1900);
    c.yday = esuc_pkg::YDAY_W'(days);
    mon = 0;
    while (mon < 11 && days >= days_in_month(mon, yr)) begin
      days -= days_in_month(mon, yr);
      mon++;
    end
    c.month  = esuc_pkg::MON_W'(mon);
    c.mday   = esuc_pkg::MDAY_W'(days + 1);
    c.hour   = esuc_pkg::HOUR_W'(tod / 3600);
    c.minute = esuc_pkg::MIN_W'((tod % 3600) / 60);
    c.second = esuc_pkg::SEC_W'(tod % 60);
    c.wday   = esuc_pkg::WDAY_W'((secs / SECONDS_PER_DAY + 4) % 7);
    return c;
  endfunction

  task automatic add_row(input longint unsigned seconds, input bit literal,
                         input calendar_t expected);
    stimulus_row_t row;
    row.seconds  = seconds;
    row.literal  = literal;
    row.expected = expected;
    directed_rows.push_back(row);
  endtask

  task automatic check_field(input string name, input longint unsigned exp_val,
                             input longint unsigned act_val);
    if (exp_val != act_val) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
    end
  endtask

  task automatic send_seconds(input longint unsigned seconds, input calendar_t expected);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    epoch_seconds_i <= seconds[esuc_pkg::SECS_W-1:0];
    do @(posedge clk_i); while (!in_ready_o);
    pending_dates.push_back(expected);
    @(negedge clk_i);
  endtask

  function automatic longint unsigned random_seconds();
    longint unsigned r;
    longint unsigned y;
    longint unsigned m;
    longint unsigned d;
    longint unsigned tod;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return r % (LAST_SECOND + 1);
      5, 6, 7: begin
        // Month and year edges, where the calendar walk is easiest to get wrong.
        y = ($urandom_range(0, 2) == 0) ? $urandom_range(1970, 2110)
                                        : $urandom_range(1970, esuc_pkg::LAST_YEAR);
        m = $urandom_range(0, 11);
        d = $urandom_range(0, 1) ? 1 : days_in_month(m, y);
        case ($urandom_range(0, 2))
          0:       tod = 0;
          1:       tod = SECONDS_PER_DAY - 1;
          default: tod = r % SECONDS_PER_DAY;
        endcase
        return epoch_of(y, m, d) + tod;
      end
      8:       return LAST_SECOND + 1 + r % (TOP_SECOND - LAST_SECOND);
      default: return longint'($urandom);
    endcase
  endfunction

  initial begin
    calendar_t   no_date;
    int unsigned i;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    epoch_seconds_i = '0;
    out_ready_i     = 1'b0;
    error_count     = 0;
    stall_cycles    = 0;
    idling_on       = 1'b1;
    no_date         = calendar_t'{13'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 3'd0, 9'd0, 1'b0};

    add_row(0, 1'b1, calendar_t'{13'd70, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0, 3'd4, 9'd0, 1'b0});
    add_row(SECONDS_PER_DAY - 1, 1'b1,
            calendar_t'{13'd70, 4'd0, 5'd1, 5'd23, 6'd59, 6'd59, 3'd4, 9'd0, 1'b0});
    add_row(LAST_SECOND, 1'b1,
            calendar_t'{13'd8099, 4'd11, 5'd31, 5'd23, 6'd59, 6'd59, 3'd5, 9'd364, 1'b0});
    add_row(LAST_SECOND + 1, 1'b1,
            calendar_t'{13'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 3'd0, 9'd0, 1'b1});
    add_row(TOP_SECOND, 1'b1,
            calendar_t'{13'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 3'd0, 9'd0, 1'b1});
    add_row(epoch_of(1970, 11, 31) + SECONDS_PER_DAY - 1, 1'b0, no_date);
    add_row(epoch_of(1972, 1, 29) + 43200, 1'b0, no_date);
    add_row(epoch_of(1972, 11, 31) + SECONDS_PER_DAY - 1, 1'b0, no_date);
    add_row(epoch_of(1999, 11, 31) + SECONDS_PER_DAY - 1, 1'b0, no_date);
    add_row(epoch_of(2000, 1, 29), 1'b0, no_date);
    add_row(epoch_of(2000, 11, 31) + SECONDS_PER_DAY - 1, 1'b0, no_date);
    add_row(epoch_of(2100, 1, 28) + 3599, 1'b0, no_date);
    add_row(epoch_of(2100, 2, 1), 1'b0, no_date);
    add_row(epoch_of(2400, 1, 29) + 59, 1'b0, no_date);
    add_row(epoch_of(9999, 0, 1), 1'b0, no_date);
    add_row(64'd2147483647, 1'b0, no_date);
    add_row(64'd1 << 32, 1'b0, no_date);
    add_row(64'd1 << 37, 1'b0, no_date);
    add_row(64'h2A_AAAA_AAAA, 1'b0, no_date);
    add_row(64'h15_5555_5555, 1'b0, no_date);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[k]) begin
      send_seconds(directed_rows[k].seconds,
                   directed_rows[k].literal ? directed_rows[k].expected
                                            : predict_calendar(directed_rows[k].seconds));
    end

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      longint unsigned secs;
      idling_on = (i < RANDOM_ITEMS - CALM_ITEMS);
      secs = random_seconds();
      send_seconds(secs, predict_calendar(secs));
    end
    in_valid_i <= 1'b0;

    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0 && pending_dates.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // The receiver stalls in bursts while idling is enabled.
  initial begin
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (idling_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    calendar_t actual;
    calendar_t expected;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
        $display("== FAIL ==");
        $finish;
      end else if (out_valid_o && out_ready_i) begin
        actual = calendar_t'{year_since_1900_o, month_index_o, day_of_month_o, hour_of_day_o,
                             minute_of_hour_o, second_of_minute_o, weekday_o, day_of_year_o,
                             range_error_o};
        if (pending_dates.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result transaction, expected none, actual %h",
                   $time, actual);
        end else begin
          expected = pending_dates.pop_front();
          check_field("year_since_1900", expected.year, actual.year);
          check_field("month_index", expected.month, actual.month);
          check_field("day_of_month", expected.mday, actual.mday);
          check_field("hour_of_day", expected.hour, actual.hour);
          check_field("minute_of_hour", expected.minute, actual.minute);
          check_field("second_of_minute", expected.second, actual.second);
          check_field("weekday", expected.wday, actual.wday);
          check_field("day_of_year", expected.yday, actual.yday);
          check_field("range_error", expected.range_error, actual.range_error);
        end
      end
    end
  end

endmodule

>>> epoch_seconds_to_utc_calendar_unit.f
+incdir+src
src/esuc_pkg.sv
src/esuc_ctrl.sv
src/esuc_dp.sv
src/epoch_seconds_to_utc_calendar_unit.sv
src/esuc_checker.sv
test/tb.sv
